### hw/rtl/ffh_pkg.sv
// Shared types and constants of the filtered feature histogram.
package ffh_pkg;

  typedef enum logic [2:0] {
    OP_LOAD_EXCL = 3'd0,
    OP_HEADER    = 3'd1,
    OP_FEATURE   = 3'd2,
    OP_READ_CNT  = 3'd3,
    OP_READ_DOCS = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_NONE6     = 3'd6,
    OP_NONE7     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_RANGE     = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_MIN_DATE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DATE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FEAT_USE = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] record_id;
    logic [31:0] record_date;
    logic [15:0] feature_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic        accepted;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_e         op;
    logic [31:0] record_id;
    logic        date_ok;
    logic        index_ok;
    logic [15:0] feature_index;
  } cmd_t;

endpackage

### hw/rtl/filtered_feature_histogram_top.sv
// Top level of the filtered feature histogram.
// Input channel in_valid_i/in_stall_o carries one command beat (op, id, date,
// feature index); output channel out_valid_o/out_stall_i returns exactly one
// result beat per command, in order.
// A front stage registers each beat and checks the date window and feature
// range; a two-entry queue decouples it from the back sequencer.
// Back steps per item: load and read-docs go straight to the result; a
// feature or counter read does a memory read, then a write; a header runs
// binary-search probe and compare steps until a hit, a miss or a date
// outside the window; a clear sweeps the counter memory. The back takes the
// next item in the cycle its result beat leaves, and no item before that.
// The counter memory port sets the feature rate; the search loop sets
// the header rate.
// After reset the back sweeps the counter memory and takes no item
// meanwhile; configuration writes are taken at any time.
// When the receiver stalls, the result holds and the back stops; the queue
// and front keep taking beats until full.
// Configuration: cfg_we_i with cfg_idx_i 0 min date, 1 max date, 2 features in use.
module filtered_feature_histogram_top #(
  parameter int unsigned NUM_FEATURES = 4096,
  parameter int unsigned MAX_EXCLUDED = 1024,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ffh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ffh_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ffh_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ffh_pkg::out_item_t           out_data_o
);
  import ffh_pkg::*;

  logic f_valid, f_stall, b_valid, b_stall;
  cmd_t f_cmd, b_cmd;

  ffh_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(f_valid), .cmd_stall_i(f_stall), .cmd_o(f_cmd),
    .num_features_i(32'(NUM_FEATURES))
  );

  ffh_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_data_o(b_cmd)
  );

  ffh_back #(
    .NUM_FEATURES(NUM_FEATURES), .MAX_EXCLUDED(MAX_EXCLUDED), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_stall_o(b_stall), .cmd_i(b_cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

### hw/rtl/ffh_front.sv
// Front part: accepts items, checks date window and feature index range.
module ffh_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [ffh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ffh_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ffh_pkg::in_item_t      in_data_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_stall_i,
  output ffh_pkg::cmd_t          cmd_o,
  input  logic [31:0]            num_features_i
);
  import ffh_pkg::*;

  logic [31:0] min_date_q, max_date_q;
  logic [12:0] feat_use_q;
  logic        valid_q;
  cmd_t        cmd_q;
  cmd_t        cmd_d;
  logic        take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_date_q <= '0;
      max_date_q <= '1;
      feat_use_q <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_DATE: min_date_q <= cfg_data_i;
        CFG_MAX_DATE: max_date_q <= cfg_data_i;
        CFG_FEAT_USE: feat_use_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Classification of the incoming beat.
  always_comb begin
    cmd_d.op = op_e'(in_data_i.op);
    cmd_d.record_id = in_data_i.record_id;
    cmd_d.date_ok = (in_data_i.record_date >= min_date_q) &&
                    (in_data_i.record_date <= max_date_q);
    cmd_d.index_ok = ({16'd0, in_data_i.feature_index} < {19'd0, feat_use_q}) &&
                     ({16'd0, in_data_i.feature_index} < num_features_i);
    cmd_d.feature_index = in_data_i.feature_index;
  end

  assign in_stall_o = valid_q && cmd_stall_i;
  assign take = in_valid_i && !in_stall_o;

  // Output stage of the front part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o = cmd_q;
endmodule

### hw/rtl/ffh_queue.sv
// Two-entry queue between the front and the back part.
module ffh_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_stall_o,
  input  ffh_pkg::cmd_t  wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_stall_i,
  output ffh_pkg::cmd_t  rd_data_o
);
  import ffh_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign push = wr_valid_i && !wr_stall_o;
  assign pop = rd_valid_o && !rd_stall_i;
  assign rd_data_o = mem_q[rp_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end
endmodule

### hw/rtl/ffh_back.sv
// Back part: exclusion table search, counter memory and result register.
module ffh_back #(
  parameter int unsigned NUM_FEATURES = 4096,
  parameter int unsigned MAX_EXCLUDED = 1024,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_stall_o,
  input  ffh_pkg::cmd_t         cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ffh_pkg::out_item_t    out_data_o
);
  import ffh_pkg::*;

  localparam int unsigned FW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int unsigned EW = (MAX_EXCLUDED > 1) ? $clog2(MAX_EXCLUDED) : 1;
  localparam int unsigned CW = $clog2(MAX_EXCLUDED + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RD     = 7'b0000010,
    S_WR     = 7'b0000100,
    S_PROBE  = 7'b0001000,
    S_CMP    = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_FEATURES];
  logic [31:0]            excl_mem [MAX_EXCLUDED];
  logic [COUNT_WIDTH-1:0] cnt_rd_q;
  logic [31:0]            excl_rd_q;
  logic [FW-1:0]          clr_ptr_q;
  logic                   clr_reply_q;
  logic [CW-1:0]          excl_cnt_q;
  logic [COUNT_WIDTH-1:0] docs_q;
  logic                   open_q;
  logic signed [SW-1:0]   lo_q, hi_q, mid;
  cmd_t                   cmd_q;
  out_item_t              res_q;
  out_item_t              res_init;
  logic                   res_valid_q;
  logic                   res_free;
  logic                   take;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [FW-1:0]          fidx;
  logic [SW:0]            mid_sum;

  // A new command is taken only once the previous result beat has left.
  assign res_free = !res_valid_q || !out_stall_i;
  assign take = (state_q == S_IDLE) && cmd_valid_i && res_free;
  assign cmd_stall_o = (state_q != S_IDLE) || !res_free;
  assign fidx = cmd_q.feature_index[FW-1:0];
  assign cnt_inc = (&cnt_rd_q) ? cnt_rd_q : cnt_rd_q + 1'b1;
  assign mid_sum = {lo_q[SW-1], lo_q} + {hi_q[SW-1], hi_q};
  assign mid = mid_sum[SW:1];
  assign out_valid_o = res_valid_q;
  assign out_data_o = res_q;

  // Result fields that are known when the command is taken.
  always_comb begin
    res_init = '0;
    if (op_e'(cmd_i.op) == OP_LOAD_EXCL && excl_cnt_q == CW'(MAX_EXCLUDED))
      res_init.status = ST_TABLE_FULL;
    if (op_e'(cmd_i.op) == OP_READ_DOCS) res_init.read_value = 32'(docs_q);
  end

  // Sequencer state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (take) begin
        priority if (op_e'(cmd_i.op) == OP_FEATURE || op_e'(cmd_i.op) == OP_READ_CNT)
          state_d = S_RD;
        else if (op_e'(cmd_i.op) == OP_HEADER)
          state_d = S_PROBE;
        else if (op_e'(cmd_i.op) == OP_CLEAR)
          state_d = S_CLEAR;
        else
          state_d = S_OUT;
      end
      S_RD:    state_d = S_WR;
      S_WR:    state_d = S_OUT;
      S_PROBE: state_d = (!cmd_q.date_ok || lo_q > hi_q) ? S_OUT : S_CMP;
      S_CMP:   state_d = (excl_rd_q == cmd_q.record_id) ? S_OUT : S_PROBE;
      // The sweep after reset answers nothing; a clear command gets its beat.
      S_CLEAR: state_d = (clr_ptr_q == FW'(NUM_FEATURES - 1)) ?
                         (clr_reply_q ? S_OUT : S_IDLE) : S_CLEAR;
      S_OUT:   state_d = res_valid_q ? S_OUT : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers and result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_ptr_q <= '0;
      clr_reply_q <= 1'b0;
      excl_cnt_q <= '0;
      docs_q <= '0;
      open_q <= 1'b0;
      res_valid_q <= 1'b0;
      res_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && !out_stall_i) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          lo_q <= '0;
          hi_q <= SW'({1'b0, excl_cnt_q}) - 1'b1;
          if (take) begin
            res_q <= res_init;
            unique case (op_e'(cmd_i.op))
              OP_LOAD_EXCL: begin
                if (excl_cnt_q != CW'(MAX_EXCLUDED)) excl_cnt_q <= excl_cnt_q + 1'b1;
              end
              OP_CLEAR: begin
                clr_ptr_q <= '0;
                clr_reply_q <= 1'b1;
                excl_cnt_q <= '0;
                docs_q <= '0;
                open_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_WR: begin
          if (!cmd_q.index_ok) begin
            res_q.status <= ST_RANGE;
          end else if (cmd_q.op == OP_READ_CNT) begin
            res_q.read_value <= 32'(cnt_rd_q);
          end
        end
        S_PROBE: begin
          if (!cmd_q.date_ok || lo_q > hi_q) begin
            open_q <= cmd_q.date_ok;
            res_q.accepted <= cmd_q.date_ok;
            if (cmd_q.date_ok && !(&docs_q)) docs_q <= docs_q + 1'b1;
          end
        end
        S_CMP: begin
          if (excl_rd_q == cmd_q.record_id) begin
            open_q <= 1'b0;
          end else if (excl_rd_q > cmd_q.record_id) begin
            hi_q <= mid - 1'b1;
          end else begin
            lo_q <= mid + 1'b1;
          end
        end
        S_CLEAR: clr_ptr_q <= clr_ptr_q + 1'b1;
        S_OUT: if (!res_valid_q) res_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Latched command for the multi-cycle operations.
  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
  end

  // Counter memory: one read and at most one write per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) cnt_mem[clr_ptr_q] <= '0;
    else if (state_q == S_WR && cmd_q.op == OP_FEATURE && cmd_q.index_ok && open_q)
      cnt_mem[fidx] <= cnt_inc;
    cnt_rd_q <= cnt_mem[fidx];
  end

  // Exclusion table memory.
  always_ff @(posedge clk_i) begin
    if (take && op_e'(cmd_i.op) == OP_LOAD_EXCL && excl_cnt_q != CW'(MAX_EXCLUDED))
      excl_mem[excl_cnt_q[EW-1:0]] <= cmd_i.record_id;
    excl_rd_q <= excl_mem[mid[EW-1:0]];
  end
endmodule
